// ===== rtl/ssa_pkg.sv =====
`timescale 1ns / 1ps

package ssa_pkg;

  // sample and result field widths
  localparam int SAMPLE_WIDTH = 16;
  localparam int CNT_OUT_W    = 17;
  localparam int MEAN_W       = 24;
  localparam int VAR_W        = 39;
  localparam int SD_W         = 24;

  // finalizer word sizes; products and their sums are kept modulo 2^64
  localparam int WORD_W     = 64;
  localparam int HALF_W     = 32;
  localparam int DIV_W      = WORD_W + 8;
  localparam int DIV_STEPS  = DIV_W;
  localparam int SQRT_STEPS = WORD_W / 2;
  localparam int MUL_STEPS  = 6;
  localparam int STEP_W     = 7;

  // running min and max start values
  localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // multiplier sequence steps
  localparam logic [2:0] MUL_NSQ_LO = 3'd0;
  localparam logic [2:0] MUL_NSQ_HI = 3'd1;
  localparam logic [2:0] MUL_SM_LO  = 3'd2;
  localparam logic [2:0] MUL_SM_X   = 3'd3;
  localparam logic [2:0] MUL_DIV    = 3'd4;
  localparam logic [2:0] MUL_DRAIN  = 3'd5;

  // controller to datapath commands
  typedef struct packed {
    logic       acc_en;
    logic       mul_en;
    logic [2:0] mul_step;
    logic       div_load;
    logic       div_sel_var;
    logic       div_step;
    logic       cap_mean;
    logic       cap_var;
    logic       sqrt_load;
    logic       sqrt_step;
    logic       load_out;
  } ssa_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic multi;
  } ssa_status_t;

endpackage

// ===== rtl/sample_statistics_accumulator.sv =====
`timescale 1ns / 1ps
// throughput: one sample per cycle while a set is being accumulated
// finalize: a 6-step multiply, then a 72-step restoring division for the mean; sets of two or more samples
//   follow with a second 72-step division for the variance and a 32-step square root
// in_ready stays low while a set is finalized; the next set starts once the result is registered
// reset: synchronous active-low rst_n clears control and all accumulators, no result pending
module sample_statistics_accumulator #(
  parameter int MAX_COUNT = 65536
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [ssa_pkg::SAMPLE_WIDTH-1:0] in_sample,
  input  logic                                   in_last,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [ssa_pkg::CNT_OUT_W-1:0]          out_count,
  output logic signed [ssa_pkg::SAMPLE_WIDTH-1:0] out_minimum,
  output logic signed [ssa_pkg::SAMPLE_WIDTH-1:0] out_maximum,
  output logic signed [ssa_pkg::MEAN_W-1:0]      out_mean_q8,
  output logic [ssa_pkg::VAR_W-1:0]              out_variance_q8,
  output logic [ssa_pkg::SD_W-1:0]               out_stddev_q8,
  output logic                                   out_single_sample,
  output logic                                   out_count_overflow
);

  ssa_pkg::ssa_cmd_t    cmd;
  ssa_pkg::ssa_status_t status;

  // sequencer
  ssa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // accumulators, finalizer arithmetic and result register
  ssa_dp #(
    .MAX_COUNT (MAX_COUNT)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_sample          (in_sample),
    .cmd                (cmd),
    .status             (status),
    .out_count          (out_count),
    .out_minimum        (out_minimum),
    .out_maximum        (out_maximum),
    .out_mean_q8        (out_mean_q8),
    .out_variance_q8    (out_variance_q8),
    .out_stddev_q8      (out_stddev_q8),
    .out_single_sample  (out_single_sample),
    .out_count_overflow (out_count_overflow)
  );

endmodule

// ===== rtl/ssa_ctrl.sv =====
`timescale 1ns / 1ps

module ssa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ssa_pkg::ssa_status_t status,
  output ssa_pkg::ssa_cmd_t    cmd
);

  localparam logic [2:0] S_ACC   = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DMEAN = 3'd2;
  localparam logic [2:0] S_VLOAD = 3'd3;
  localparam logic [2:0] S_DVAR  = 3'd4;
  localparam logic [2:0] S_SLOAD = 3'd5;
  localparam logic [2:0] S_SQRT  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam logic [ssa_pkg::STEP_W-1:0] MUL_LAST  = ssa_pkg::STEP_W'(ssa_pkg::MUL_STEPS - 1);
  localparam logic [ssa_pkg::STEP_W-1:0] DIV_LAST  = ssa_pkg::STEP_W'(ssa_pkg::DIV_STEPS - 1);
  localparam logic [ssa_pkg::STEP_W-1:0] SQRT_LAST = ssa_pkg::STEP_W'(ssa_pkg::SQRT_STEPS - 1);

  logic [2:0]                  state_r, state_nxt;
  logic [ssa_pkg::STEP_W-1:0]  cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // sequencing of accumulation and the per-set finalizer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_ACC: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc_en = 1'b1;
          if (in_last) begin
            state_nxt = S_MUL;
            cnt_nxt   = '0;
          end
        end
      end
      S_MUL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = cnt_r[2:0];
        if (cnt_r == MUL_LAST) begin
          cmd.div_load = 1'b1;
          state_nxt    = S_DMEAN;
          cnt_nxt      = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DMEAN: begin
        cmd.div_step = 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_VLOAD;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_VLOAD: begin
        cmd.cap_mean = 1'b1;
        if (status.multi) begin
          cmd.div_load    = 1'b1;
          cmd.div_sel_var = 1'b1;
          state_nxt       = S_DVAR;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DVAR: begin
        cmd.div_step = 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_SLOAD;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SLOAD: begin
        cmd.cap_var   = 1'b1;
        cmd.sqrt_load = 1'b1;
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == SQRT_LAST) begin
          state_nxt = S_OUT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_OUT: begin
        // wait until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
        cnt_nxt   = '0;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/ssa_dp.sv =====
`timescale 1ns / 1ps

module ssa_dp #(
  parameter int MAX_COUNT = 65536
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic signed [ssa_pkg::SAMPLE_WIDTH-1:0] in_sample,
  input  ssa_pkg::ssa_cmd_t                      cmd,
  output ssa_pkg::ssa_status_t                   status,
  output logic [ssa_pkg::CNT_OUT_W-1:0]          out_count,
  output logic signed [ssa_pkg::SAMPLE_WIDTH-1:0] out_minimum,
  output logic signed [ssa_pkg::SAMPLE_WIDTH-1:0] out_maximum,
  output logic signed [ssa_pkg::MEAN_W-1:0]      out_mean_q8,
  output logic [ssa_pkg::VAR_W-1:0]              out_variance_q8,
  output logic [ssa_pkg::SD_W-1:0]               out_stddev_q8,
  output logic                                   out_single_sample,
  output logic                                   out_count_overflow
);

  localparam int SW   = ssa_pkg::SAMPLE_WIDTH;
  localparam int WW   = ssa_pkg::WORD_W;
  localparam int HW   = ssa_pkg::HALF_W;
  localparam int DW   = ssa_pkg::DIV_W;
  localparam int CW   = $clog2(MAX_COUNT + 1);
  localparam int SUMW = CW + SW;
  localparam int SQW  = CW + 2 * SW - 2;
  localparam int RW   = HW + 2;

  // accumulators
  logic [CW-1:0]          count_r;
  logic signed [SUMW-1:0] sum_r;
  logic [SQW-1:0]         sumsq_r;
  logic signed [SW-1:0]   min_r;
  logic signed [SW-1:0]   max_r;
  logic                   ovf_r;

  logic signed [2*SW-1:0] sq;
  logic                   limit_hit;

  assign sq        = in_sample * in_sample;
  assign limit_hit = (count_r == CW'(MAX_COUNT));

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_out) begin
      count_r <= '0;
      sum_r   <= '0;
      sumsq_r <= '0;
      min_r   <= ssa_pkg::SMP_MAX;
      max_r   <= ssa_pkg::SMP_MIN;
      ovf_r   <= 1'b0;
    end else if (cmd.acc_en) begin
      if (limit_hit) begin
        ovf_r <= 1'b1;
      end else begin
        count_r <= count_r + 1'b1;
        sum_r   <= sum_r + SUMW'(in_sample);
        sumsq_r <= sumsq_r + SQW'(unsigned'(sq));
        if (in_sample < min_r) begin
          min_r <= in_sample;
        end
        if (in_sample > max_r) begin
          max_r <= in_sample;
        end
      end
    end
  end

  // set values widened to the finalizer word
  logic            sum_neg;
  logic [SUMW-1:0] sum_mag;
  logic [WW-1:0]   n64, n_m1, n_eff, sm64, sumsq64;

  assign sum_neg = sum_r[SUMW-1];
  assign sum_mag = sum_neg ? SUMW'(-sum_r) : SUMW'(sum_r);
  assign n64     = WW'(count_r);
  assign n_m1    = n64 - 1'b1;
  assign n_eff   = (count_r == '0) ? WW'(1) : n64;
  assign sm64    = WW'(sum_mag);
  assign sumsq64 = WW'(sumsq_r);

  assign status.multi = (count_r > CW'(1));

  // shared 32x32 multiplier, product registered
  logic [HW-1:0] mul_a, mul_b;
  logic [WW-1:0] mul_p;
  logic [WW-1:0] prod_r;
  logic [WW-1:0] p_nsq_r, p_sm2_r, p_div_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_step)
      ssa_pkg::MUL_NSQ_LO: begin
        mul_a = n64[HW-1:0];
        mul_b = sumsq64[HW-1:0];
      end
      ssa_pkg::MUL_NSQ_HI: begin
        mul_a = n64[HW-1:0];
        mul_b = sumsq64[WW-1:HW];
      end
      ssa_pkg::MUL_SM_LO: begin
        mul_a = sm64[HW-1:0];
        mul_b = sm64[HW-1:0];
      end
      ssa_pkg::MUL_SM_X: begin
        mul_a = sm64[HW-1:0];
        mul_b = sm64[WW-1:HW];
      end
      ssa_pkg::MUL_DIV: begin
        mul_a = n64[HW-1:0];
        mul_b = n_m1[HW-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // each step after the first stores or folds in the product of the step before it
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= mul_p;
      case (cmd.mul_step)
        ssa_pkg::MUL_NSQ_HI: p_nsq_r <= prod_r;
        ssa_pkg::MUL_SM_LO:  p_nsq_r <= p_nsq_r + {prod_r[HW-1:0], {HW{1'b0}}};
        ssa_pkg::MUL_SM_X:   p_sm2_r <= prod_r;
        ssa_pkg::MUL_DIV:    p_sm2_r <= p_sm2_r + {prod_r[HW-2:0], {(HW+1){1'b0}}};
        ssa_pkg::MUL_DRAIN:  p_div_r <= prod_r;
        default: begin
        end
      endcase
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [DW-1:0] dq_r;
  logic [WW-1:0] drem_r, ddiv_r;
  logic [WW:0]   rem_sh, rem_sub;
  logic          rem_ge;
  logic [WW-1:0] d64;

  assign d64     = p_nsq_r - p_sm2_r;
  assign rem_sh  = {drem_r, dq_r[DW-1]};
  assign rem_sub = rem_sh - {1'b0, ddiv_r};
  assign rem_ge  = (rem_sh >= {1'b0, ddiv_r});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      drem_r <= '0;
      if (cmd.div_sel_var) begin
        dq_r   <= {d64, 8'b0};
        ddiv_r <= p_div_r;
      end else begin
        dq_r   <= {8'b0, sm64[WW-9:0], 8'b0};
        ddiv_r <= n_eff;
      end
    end else if (cmd.div_step) begin
      drem_r <= rem_ge ? rem_sub[WW-1:0] : rem_sh[WW-1:0];
      dq_r   <= {dq_r[DW-2:0], rem_ge};
    end
  end

  // digit-by-digit square root, two radicand bits per cycle
  logic [WW-1:0] sx_r;
  logic [RW-1:0] srem_r;
  logic [HW-1:0] sroot_r;
  logic [RW+1:0] srem_sh, strial, srem_sub;
  logic          s_ge;

  assign srem_sh  = {srem_r, sx_r[WW-1:WW-2]};
  assign strial   = {2'b0, sroot_r, 2'b01};
  assign srem_sub = srem_sh - strial;
  assign s_ge     = (srem_sh >= strial);

  always_ff @(posedge clk) begin
    if (cmd.sqrt_load) begin
      sx_r    <= {dq_r[WW-9:0], 8'b0};
      srem_r  <= '0;
      sroot_r <= '0;
    end else if (cmd.sqrt_step) begin
      sx_r    <= {sx_r[WW-3:0], 2'b0};
      srem_r  <= s_ge ? srem_sub[RW-1:0] : srem_sh[RW-1:0];
      sroot_r <= {sroot_r[HW-2:0], s_ge};
    end
  end

  // mean and variance captures
  logic [WW-1:0]                 mean_val;
  logic signed [ssa_pkg::MEAN_W-1:0] mean_r;
  logic [ssa_pkg::VAR_W-1:0]     var_r;

  assign mean_val = sum_neg ? (WW'(0) - dq_r[WW-1:0]) : dq_r[WW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.cap_mean) begin
      mean_r <= signed'(mean_val[ssa_pkg::MEAN_W-1:0]);
    end
    if (cmd.cap_var) begin
      var_r <= dq_r[ssa_pkg::VAR_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_count          <= n64[ssa_pkg::CNT_OUT_W-1:0];
      out_minimum        <= min_r;
      out_maximum        <= max_r;
      out_mean_q8        <= mean_r;
      out_variance_q8    <= status.multi ? var_r : '0;
      out_stddev_q8      <= status.multi ? sroot_r[ssa_pkg::SD_W-1:0] : '0;
      out_single_sample  <= (count_r == CW'(1));
      out_count_overflow <= ovf_r;
    end
  end

endmodule

// ===== rtl/ssa_checker.sv =====
`timescale 1ns / 1ps

module ssa_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic signed [ssa_pkg::SAMPLE_WIDTH-1:0] in_sample,
  input logic                                   in_last,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic [ssa_pkg::CNT_OUT_W-1:0]          out_count,
  input logic signed [ssa_pkg::SAMPLE_WIDTH-1:0] out_minimum,
  input logic signed [ssa_pkg::SAMPLE_WIDTH-1:0] out_maximum,
  input logic signed [ssa_pkg::MEAN_W-1:0]      out_mean_q8,
  input logic [ssa_pkg::VAR_W-1:0]              out_variance_q8,
  input logic [ssa_pkg::SD_W-1:0]               out_stddev_q8,
  input logic                                   out_single_sample,
  input logic                                   out_count_overflow
);

  // stalled result keeps its count, mean, variance and stddev
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_mean_q8)
      && $stable(out_variance_q8) && $stable(out_stddev_q8))
    else $error("result changed while stalled");

  // a last-sample transaction closes the input until the set is finalized
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input open during finalize");

  // a new result reopens the input
  a_result_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("input still closed after result");

  // single-sample sets carry no spread
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_single_sample |-> out_count == 1 && out_variance_q8 == 0
      && out_stddev_q8 == 0 && out_minimum == out_maximum)
    else $error("single-sample result inconsistent");

  // minimum never exceeds maximum
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_minimum <= out_maximum)
    else $error("minimum above maximum");

endmodule

bind sample_statistics_accumulator ssa_checker u_ssa_checker (.*);
